FILE: rtl/ols_pkg.sv
package ols_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] OP_INSERT_AT     = 4'd0;
  localparam logic [3:0] OP_DELETE_AT     = 4'd1;
  localparam logic [3:0] OP_READ_AT       = 4'd2;
  localparam logic [3:0] OP_LOCATE        = 4'd3;
  localparam logic [3:0] OP_SORTED_INSERT = 4'd4;
  localparam logic [3:0] OP_SORTED_UNIQUE = 4'd5;
  localparam logic [3:0] OP_DELETE_VALUE  = 4'd6;
  localparam logic [3:0] OP_SORT          = 4'd7;
  localparam logic [3:0] OP_DEDUP         = 4'd8;
  localparam logic [3:0] OP_CLEAR         = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_PRESENT  = 3'd5;

  typedef struct packed {
    logic [2:0]    status;
    logic [31:0]   read_value;
    logic [5:0]    found_slot;
    logic [5:0]    removed;
    logic [CW-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/ols_ram.sv
module ols_ram
  import ols_pkg::*;
(
  input  logic        clk_i,
  input  mem_req_t    req_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem [CAPACITY];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ols_ctrl.sv
module ols_ctrl
  import ols_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  operation_i,
  input  logic [31:0] item_value_i,
  input  logic [5:0]  slot_i,
  output logic        res_valid_o,
  input  logic        res_take_i,
  output res_t        res_o,
  output mem_req_t    mem_o,
  input  logic [31:0] rdata_i
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DONE     = 5'd1;
  localparam logic [4:0] S_RD_WAIT  = 5'd2;
  localparam logic [4:0] S_FIND_RD  = 5'd3;
  localparam logic [4:0] S_FIND_CHK = 5'd4;
  localparam logic [4:0] S_LT_RD    = 5'd5;
  localparam logic [4:0] S_LT_CHK   = 5'd6;
  localparam logic [4:0] S_UP_RD    = 5'd7;
  localparam logic [4:0] S_UP_WR    = 5'd8;
  localparam logic [4:0] S_DN_RD    = 5'd9;
  localparam logic [4:0] S_DN_WR    = 5'd10;
  localparam logic [4:0] S_DV_RD    = 5'd11;
  localparam logic [4:0] S_DV_CHK   = 5'd12;
  localparam logic [4:0] S_DD_RD    = 5'd13;
  localparam logic [4:0] S_DD_LD    = 5'd14;
  localparam logic [4:0] S_DD_SRD   = 5'd15;
  localparam logic [4:0] S_DD_SCHK  = 5'd16;
  localparam logic [4:0] S_SO_START = 5'd17;
  localparam logic [4:0] S_SO_LD    = 5'd18;
  localparam logic [4:0] S_SO_RD    = 5'd19;
  localparam logic [4:0] S_SO_CHK   = 5'd20;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [4:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, p_q, p_d;
  logic [3:0]    op_q, op_d;
  logic [31:0]   val_q, val_d, x_q, x_d;
  logic          swp_q, swp_d;
  res_t          res_q, res_d;
  logic          accept;

  assign accept      = in_valid_i && (st_q == S_IDLE);
  assign in_stall_o  = (st_q != S_IDLE);
  assign res_valid_o = (st_q == S_DONE);

  always_comb begin
    res_o = res_q;
    res_o.entry_count = cnt_q;
  end

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    i_d   = i_q;
    j_d   = j_q;
    p_d   = p_q;
    op_d  = op_q;
    val_d = val_q;
    x_d   = x_q;
    swp_d = swp_q;
    res_d = res_q;
    mem_o = '0;

    case (st_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = operation_i;
          val_d = item_value_i;
          res_d = '0;
          i_d   = '0;
          j_d   = '0;
          st_d  = S_DONE;
          case (operation_i)
            OP_INSERT_AT: begin
              if (cnt_q == CAP_C) begin
                res_d.status = ST_FULL;
              end else if (slot_i == '0 ||
                           {1'b0, slot_i} > ({1'b0, cnt_q} + 7'd1)) begin
                res_d.status = ST_BADPOS;
              end else begin
                p_d  = CW'(slot_i - 6'd1);
                i_d  = cnt_q;
                st_d = S_UP_RD;
              end
            end
            OP_DELETE_AT, OP_READ_AT: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
              end else if (slot_i == '0 || {1'b0, slot_i} > {1'b0, cnt_q}) begin
                res_d.status = ST_BADPOS;
              end else if (operation_i == OP_DELETE_AT) begin
                i_d  = CW'(slot_i - 6'd1);
                st_d = S_DN_RD;
              end else begin
                mem_o.raddr = AW'(slot_i - 6'd1);
                res_d.found_slot = slot_i;
                st_d = S_RD_WAIT;
              end
            end
            OP_LOCATE, OP_SORTED_UNIQUE: st_d = S_FIND_RD;
            OP_SORTED_INSERT: begin
              if (cnt_q == CAP_C) res_d.status = ST_FULL;
              else st_d = S_LT_RD;
            end
            OP_DELETE_VALUE: st_d = S_DV_RD;
            OP_SORT: begin
              if (cnt_q > CW'(1)) st_d = S_SO_START;
            end
            OP_DEDUP: st_d = S_DD_RD;
            OP_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      S_DONE: begin
        if (res_take_i) st_d = S_IDLE;
      end
      S_RD_WAIT: begin
        res_d.read_value = rdata_i;
        st_d = S_DONE;
      end
      S_FIND_RD: begin
        if (i_q == cnt_q) begin
          if (op_q == OP_LOCATE) begin
            res_d.status = ST_NOTFOUND;
            res_d.found_slot = 6'(cnt_q + CW'(1));
            st_d = S_DONE;
          end else if (cnt_q == CAP_C) begin
            res_d.status = ST_FULL;
            st_d = S_DONE;
          end else begin
            i_d  = '0;
            st_d = S_LT_RD;
          end
        end else begin
          mem_o.raddr = i_q[AW-1:0];
          st_d = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (rdata_i == val_q) begin
          res_d.found_slot = 6'(i_q + CW'(1));
          if (op_q != OP_LOCATE) res_d.status = ST_PRESENT;
          st_d = S_DONE;
        end else begin
          i_d  = i_q + CW'(1);
          st_d = S_FIND_RD;
        end
      end
      S_LT_RD: begin
        if (i_q == cnt_q) begin
          p_d  = i_q;
          i_d  = cnt_q;
          st_d = S_UP_RD;
        end else begin
          mem_o.raddr = i_q[AW-1:0];
          st_d = S_LT_CHK;
        end
      end
      S_LT_CHK: begin
        if ($signed(rdata_i) < $signed(val_q)) begin
          i_d  = i_q + CW'(1);
          st_d = S_LT_RD;
        end else begin
          p_d  = i_q;
          i_d  = cnt_q;
          st_d = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (i_q == p_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = p_q[AW-1:0];
          mem_o.wdata = val_q;
          cnt_d = cnt_q + CW'(1);
          res_d.found_slot = 6'(p_q + CW'(1));
          st_d = S_DONE;
        end else begin
          mem_o.raddr = AW'(i_q - CW'(1));
          st_d = S_UP_WR;
        end
      end
      S_UP_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = i_q[AW-1:0];
        mem_o.wdata = rdata_i;
        i_d  = i_q - CW'(1);
        st_d = S_UP_RD;
      end
      S_DN_RD: begin
        if (i_q + CW'(1) >= cnt_q) begin
          cnt_d = cnt_q - CW'(1);
          st_d  = S_DONE;
        end else begin
          mem_o.raddr = AW'(i_q + CW'(1));
          st_d = S_DN_WR;
        end
      end
      S_DN_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = i_q[AW-1:0];
        mem_o.wdata = rdata_i;
        i_d  = i_q + CW'(1);
        st_d = S_DN_RD;
      end
      S_DV_RD: begin
        if (i_q == cnt_q) begin
          cnt_d = j_q;
          if (res_q.removed == '0) res_d.status = ST_NOTFOUND;
          st_d = S_DONE;
        end else begin
          mem_o.raddr = i_q[AW-1:0];
          st_d = S_DV_CHK;
        end
      end
      S_DV_CHK: begin
        if (rdata_i == val_q) begin
          res_d.removed = res_q.removed + 6'd1;
        end else begin
          mem_o.we    = 1'b1;
          mem_o.waddr = j_q[AW-1:0];
          mem_o.wdata = rdata_i;
          j_d = j_q + CW'(1);
        end
        i_d  = i_q + CW'(1);
        st_d = S_DV_RD;
      end
      S_DD_RD: begin
        if (i_q == cnt_q) begin
          cnt_d = j_q;
          st_d  = S_DONE;
        end else begin
          mem_o.raddr = i_q[AW-1:0];
          st_d = S_DD_LD;
        end
      end
      S_DD_LD: begin
        x_d  = rdata_i;
        p_d  = '0;
        st_d = S_DD_SRD;
      end
      S_DD_SRD: begin
        if (p_q == j_q) begin
          // No earlier kept copy, so this entry is kept.
          mem_o.we    = 1'b1;
          mem_o.waddr = j_q[AW-1:0];
          mem_o.wdata = x_q;
          j_d  = j_q + CW'(1);
          i_d  = i_q + CW'(1);
          st_d = S_DD_RD;
        end else begin
          mem_o.raddr = p_q[AW-1:0];
          st_d = S_DD_SCHK;
        end
      end
      S_DD_SCHK: begin
        if (rdata_i == x_q) begin
          res_d.removed = res_q.removed + 6'd1;
          i_d  = i_q + CW'(1);
          st_d = S_DD_RD;
        end else begin
          p_d  = p_q + CW'(1);
          st_d = S_DD_SRD;
        end
      end
      S_SO_START: begin
        mem_o.raddr = '0;
        st_d = S_SO_LD;
      end
      S_SO_LD: begin
        x_d   = rdata_i;
        i_d   = CW'(1);
        swp_d = 1'b0;
        st_d  = S_SO_RD;
      end
      S_SO_RD: begin
        if (i_q == cnt_q) begin
          // End of a bubble pass: the carried maximum lands in the last slot.
          mem_o.we    = 1'b1;
          mem_o.waddr = AW'(i_q - CW'(1));
          mem_o.wdata = x_q;
          st_d = swp_q ? S_SO_START : S_DONE;
        end else begin
          mem_o.raddr = i_q[AW-1:0];
          st_d = S_SO_CHK;
        end
      end
      S_SO_CHK: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = AW'(i_q - CW'(1));
        if ($signed(x_q) > $signed(rdata_i)) begin
          mem_o.wdata = rdata_i;
          swp_d = 1'b1;
        end else begin
          mem_o.wdata = x_q;
          x_d = rdata_i;
        end
        i_d  = i_q + CW'(1);
        st_d = S_SO_RD;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    p_q   <= p_d;
    op_q  <= op_d;
    val_q <= val_d;
    x_q   <= x_d;
    swp_q <= swp_d;
    res_q <= res_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_C) else $error("entry count above capacity");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> (st_q != S_IDLE) && (st_q != S_DONE))
    else $error("memory write outside an operation");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && !in_valid_i) |=> $stable(cnt_q))
    else $error("count changed while idle");

endmodule

FILE: rtl/ordered_list_store_top.sv
// Clear and items rejected on arrival go straight to a result; read_at also waits for the
// registered memory read. Shifts move entries one by one, each read then written, and
// scans read one entry at a time. Sort runs bubble passes, up to count passes; dedup is
// quadratic in count. One item is processed at a time through the single read port of
// the entry memory, so the next item is accepted only after the last result is taken.
// Reset is asynchronous and active low; it empties the list and drops any pending
// result. Entry storage is not cleared.
module ordered_list_store_top
  import ols_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  operation_i,
  input  logic [31:0] item_value_i,
  input  logic [5:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] read_value_o,
  output logic [5:0]  found_slot_o,
  output logic [5:0]  removed_o,
  output logic [5:0]  entry_count_o
);

  mem_req_t    mem_req;
  logic [31:0] rdata;
  logic        res_valid, res_take;
  res_t        res;
  logic        out_valid_q;
  res_t        out_q;

  ols_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  ols_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .item_value_i (item_value_i),
    .slot_i       (slot_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .mem_o        (mem_req),
    .rdata_i      (rdata)
  );

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign read_value_o  = out_q.read_value;
  assign found_slot_o  = out_q.found_slot;
  assign removed_o     = out_q.removed;
  assign entry_count_o = 6'(out_q.entry_count);

endmodule
